// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/tlvf_pkg.sv -----
`timescale 1ns / 1ps
package tlvf_pkg;
  localparam logic [3:0] FUNC_U8    = 4'd0;
  localparam logic [3:0] FUNC_S8    = 4'd1;
  localparam logic [3:0] FUNC_U16   = 4'd2;
  localparam logic [3:0] FUNC_S16   = 4'd3;
  localparam logic [3:0] FUNC_U32   = 4'd4;
  localparam logic [3:0] FUNC_S32   = 4'd5;
  localparam logic [3:0] FUNC_FLOAT = 4'd6;
  localparam logic [3:0] FUNC_HALF  = 4'd7;

  localparam logic [7:0] EXP_REBIAS = 8'd112;

  typedef struct packed {
    logic [3:0]  func;
    logic [3:0]  byte_count;
    logic [31:0] raw_word;
  } in_item_t;

  typedef struct packed {
    logic        conv_error;
    logic [31:0] float_bits;
  } out_item_t;

  // Position of the highest set bit (0 for a zero input).
  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction
endpackage

// ----- rtl/tlvf_int_conv.sv -----
`timescale 1ns / 1ps
// Sign and magnitude to single precision with round to nearest even.
module tlvf_int_conv (
  input  logic        neg_i,
  input  logic [31:0] mag_i,
  output logic [31:0] bits_o
);
  logic [4:0]  p;
  logic [31:0] norm;
  logic [23:0] keep;
  logic [7:0]  rem_bits;
  logic        round_up;
  logic [24:0] keep_r;
  logic [7:0]  expo;

  always_comb begin
    p        = tlvf_pkg::msb_pos(mag_i);
    norm     = mag_i << (5'd31 - p);
    keep     = norm[31:8];
    rem_bits = norm[7:0];
    // Bits below the kept 24 only exist when p > 23, which norm already shows.
    round_up = rem_bits[7] && ((rem_bits[6:0] != 7'd0) || keep[0]);
    keep_r   = {1'b0, keep} + {24'd0, round_up};
    expo     = 8'd127 + {3'd0, p};
    if (mag_i == 32'd0) begin
      bits_o = 32'd0;
    end else begin
      // The hidden bit is removed by subtraction, so a rounding carry out of the
      // significand raises the exponent by one on its own.
      bits_o = {neg_i, ({expo, 23'd0} + {6'd0, keep_r} - 31'h0080_0000)};
    end
  end
endmodule

// ----- rtl/tlvf_half_conv.sv -----
`timescale 1ns / 1ps
// Half precision to single precision, exact widening.
module tlvf_half_conv (
  input  logic [15:0] half_i,
  output logic [31:0] bits_o
);
  logic        s;
  logic [4:0]  e;
  logic [9:0]  f;
  logic [4:0]  p;
  logic [9:0]  fn;
  logic [7:0]  en;

  always_comb begin
    s  = half_i[15];
    e  = half_i[14:10];
    f  = half_i[9:0];
    p  = tlvf_pkg::msb_pos({22'd0, f});
    fn = 10'(f << (5'd10 - p));
    en = tlvf_pkg::EXP_REBIAS - 8'd9 + {3'd0, p};
    if (e == 5'd0) begin
      if (f == 10'd0) begin
        bits_o = {s, 31'd0};
      end else begin
        bits_o = {s, en, fn, 13'd0};
      end
    end else if (e == 5'h1f) begin
      bits_o = {s, 8'hff, f, 13'd0};
    end else begin
      bits_o = {s, {3'd0, e} + tlvf_pkg::EXP_REBIAS, f, 13'd0};
    end
  end
endmodule

// ----- rtl/typed_log_value_to_float32.sv -----
`timescale 1ns / 1ps
// Converts a typed raw value (8/16/32-bit signed or unsigned integer, single or
// half float) to IEEE single-precision bits. An item passes through the input
// register and then the result register, and a new item is accepted every cycle
// unless a stalled output holds both registers full; the result register and a
// skid-free ready path (ready while the input register is empty or can pass its
// item on to a result register that is empty or being drained) set that rate.
// Unknown type codes or a byte count that does not match the type give +0.0
// with the error flag set. Large 32-bit integers round to nearest, ties to even.
`include "assert_macros.svh"
module typed_log_value_to_float32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // func[3:0], byte_count[7:4], raw_word[39:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // float_bits[31:0], conv_error[32], zeros above
);
  tlvf_pkg::in_item_t  in_q;
  logic                in_vld_q;
  tlvf_pkg::out_item_t out_q, out_d;
  logic                out_vld_q;
  logic                in_ready;
  logic                out_load;
  logic                int_neg;
  logic [31:0]         int_mag;
  logic [31:0]         int_bits;
  logic [31:0]         half_bits;
  logic                size_ok;

  // Stage 2 loads whenever it is empty or drained; stage 1 moves on with it.
  assign out_load      = !out_vld_q || m_axis_tready;
  assign in_ready      = !in_vld_q || out_load;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_q <= tlvf_pkg::in_item_t'({s_axis_tdata[3:0], s_axis_tdata[7:4], s_axis_tdata[39:8]});
    end
  end

  // Select sign and magnitude for the integer path.
  always_comb begin
    int_neg = 1'b0;
    int_mag = 32'd0;
    unique case (in_q.func)
      tlvf_pkg::FUNC_U8:  int_mag = {24'd0, in_q.raw_word[7:0]};
      tlvf_pkg::FUNC_S8: begin
        int_neg = in_q.raw_word[7];
        int_mag = {24'd0, int_neg ? 8'(-in_q.raw_word[7:0]) : in_q.raw_word[7:0]};
      end
      tlvf_pkg::FUNC_U16: int_mag = {16'd0, in_q.raw_word[15:0]};
      tlvf_pkg::FUNC_S16: begin
        int_neg = in_q.raw_word[15];
        int_mag = {16'd0, int_neg ? 16'(-in_q.raw_word[15:0]) : in_q.raw_word[15:0]};
      end
      tlvf_pkg::FUNC_U32: int_mag = in_q.raw_word;
      tlvf_pkg::FUNC_S32: begin
        int_neg = in_q.raw_word[31];
        int_mag = int_neg ? -in_q.raw_word : in_q.raw_word;
      end
      default: begin
        int_neg = 1'b0;
        int_mag = 32'd0;
      end
    endcase
  end

  tlvf_int_conv u_int (.neg_i(int_neg), .mag_i(int_mag), .bits_o(int_bits));
  tlvf_half_conv u_half (.half_i(in_q.raw_word[15:0]), .bits_o(half_bits));

  always_comb begin
    unique case (in_q.func)
      tlvf_pkg::FUNC_U8, tlvf_pkg::FUNC_S8: size_ok = (in_q.byte_count == 4'd1);
      tlvf_pkg::FUNC_U16, tlvf_pkg::FUNC_S16,
      tlvf_pkg::FUNC_HALF: size_ok = (in_q.byte_count == 4'd2);
      tlvf_pkg::FUNC_U32, tlvf_pkg::FUNC_S32,
      tlvf_pkg::FUNC_FLOAT: size_ok = (in_q.byte_count == 4'd4);
      default: size_ok = 1'b0;
    endcase
    out_d.conv_error = !size_ok;
    if (!size_ok) begin
      out_d.float_bits = 32'd0;
    end else if (in_q.func == tlvf_pkg::FUNC_FLOAT) begin
      out_d.float_bits = in_q.raw_word;
    end else if (in_q.func == tlvf_pkg::FUNC_HALF) begin
      out_d.float_bits = half_bits;
    end else begin
      out_d.float_bits = int_bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_vld_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.conv_error, out_q.float_bits};

  `ASSERT_CLK(a_err_zero, clk_i, rst_ni,
    m_axis_tvalid && out_q.conv_error |-> out_q.float_bits == 32'd0, "error result not +0.0")
  `ASSERT_CLK(a_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_q), "stalled result moved")
  `ASSERT_CLK(a_adv, clk_i, rst_ni,
    in_vld_q && out_load |=> m_axis_tvalid, "item lost between stages")
endmodule
